// ===== hdl/cstl_pkg.sv =====
`timescale 1ns / 1ps

package cstl_pkg;

   localparam int QUEUE_DEPTH = 4;
   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   localparam logic KIND_VALUE = 1'b0;
   localparam logic KIND_END   = 1'b1;

   localparam logic [3:0] TOK_ERROR = 4'd0;
   localparam logic [3:0] TOK_EOF   = 4'd1;
   localparam logic [3:0] TOK_IDENT = 4'd2;
   localparam logic [3:0] TOK_STR   = 4'd3;
   localparam logic [3:0] TOK_PUNCT = 4'd4;
   localparam logic [3:0] TOK_INT   = 4'd5;
   localparam logic [3:0] TOK_HEX   = 4'd6;
   localparam logic [3:0] TOK_OCT   = 4'd7;
   localparam logic [3:0] TOK_REAL  = 4'd8;

   localparam logic [3:0] ERR_NONE      = 4'd0;
   localparam logic [3:0] ERR_UNKNOWN   = 4'd1;
   localparam logic [3:0] ERR_EOF_STR   = 4'd2;
   localparam logic [3:0] ERR_EOF_ESC   = 4'd3;
   localparam logic [3:0] ERR_BAD_ESC   = 4'd4;
   localparam logic [3:0] ERR_DIGIT     = 4'd5;
   localparam logic [3:0] ERR_NO_HEX    = 4'd6;
   localparam logic [3:0] ERR_NO_FRAC   = 4'd7;
   localparam logic [3:0] ERR_NO_EXP    = 4'd8;

   localparam logic [7:0] CH_NUL       = 8'h00;
   localparam logic [7:0] CH_TAB       = 8'h09;
   localparam logic [7:0] CH_NL        = 8'h0A;
   localparam logic [7:0] CH_SPACE     = 8'h20;
   localparam logic [7:0] CH_QUOTE     = 8'h22;
   localparam logic [7:0] CH_HASH      = 8'h23;
   localparam logic [7:0] CH_PLUS      = 8'h2B;
   localparam logic [7:0] CH_MINUS     = 8'h2D;
   localparam logic [7:0] CH_DOT       = 8'h2E;
   localparam logic [7:0] CH_ZERO      = 8'h30;
   localparam logic [7:0] CH_SEVEN     = 8'h37;
   localparam logic [7:0] CH_NINE      = 8'h39;
   localparam logic [7:0] CH_UPPER_E   = 8'h45;
   localparam logic [7:0] CH_UPPER_X   = 8'h58;
   localparam logic [7:0] CH_BACKSLASH = 8'h5C;
   localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
   localparam logic [7:0] CH_LOWER_E   = 8'h65;
   localparam logic [7:0] CH_LOWER_N   = 8'h6E;
   localparam logic [7:0] CH_LOWER_T   = 8'h74;
   localparam logic [7:0] CH_LOWER_X   = 8'h78;

   typedef enum logic [3:0] {
      ST_INIT    = 4'd0,
      ST_COMMENT = 4'd1,
      ST_IDENT   = 4'd2,
      ST_STRING  = 4'd3,
      ST_ESCAPE  = 4'd4,
      ST_PUNCT   = 4'd5,
      ST_ZERO    = 4'd6,
      ST_HEXREQ  = 4'd7,
      ST_HEXSEQ  = 4'd8,
      ST_OCTSEQ  = 4'd9,
      ST_DECSEQ  = 4'd10,
      ST_FRACREQ = 4'd11,
      ST_FRACSEQ = 4'd12,
      ST_EXPSIGN = 4'd13,
      ST_EXPREQ  = 4'd14,
      ST_EXPSEQ  = 4'd15
   } lex_state_type;

   typedef struct packed {
      logic       out_kind;
      logic [7:0] value_byte;
      logic [3:0] token_kind;
      logic [3:0] error_code;
      logic       last;
   } result_type;

   typedef struct packed {
      logic [1:0] count;
      result_type res0;
      result_type res1;
   } push_type;

   typedef struct packed {
      push_type      push;
      lex_state_type next_state;
      logic          next_dot;
   } step_out_type;

endpackage

// ===== hdl/cstl_if.sv =====
`timescale 1ns / 1ps

interface cstl_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;

   modport source (output valid, output in_byte, input ready);
   modport sink (input valid, input in_byte, output ready);
endinterface

interface cstl_rsp_if;
   logic       valid;
   logic       ready;
   logic       out_kind;
   logic [7:0] value_byte;
   logic [3:0] token_kind;
   logic [3:0] error_code;
   logic       last;

   modport source (output valid, output out_kind, output value_byte, output token_kind,
                   output error_code, output last, input ready);
   modport sink (input valid, input out_kind, input value_byte, input token_kind,
                 input error_code, input last, output ready);
endinterface

// ===== hdl/cstl_step.sv =====
`timescale 1ns / 1ps

module cstl_step
   import cstl_pkg::*;
(
   input  logic [7:0]    in_byte,
   input  lex_state_type state,
   input  logic          pending_dot,
   output step_out_type  step_out
);

   typedef struct packed {
      logic          consumed;
      logic          has_res;
      result_type    res;
      lex_state_type next_state;
      logic          next_dot;
   } scan_type;

   scan_type first;
   scan_type second;

   function automatic logic is_digit(logic [7:0] c);
      return c inside {[CH_ZERO:CH_NINE]};
   endfunction

   function automatic logic is_alpha(logic [7:0] c);
      return c inside {[8'h61:8'h7A], [8'h41:8'h5A]};
   endfunction

   function automatic logic is_alnum(logic [7:0] c);
      return is_digit(c) || is_alpha(c);
   endfunction

   function automatic logic is_xdigit(logic [7:0] c);
      return is_digit(c) || (c inside {[8'h61:8'h66], [8'h41:8'h46]});
   endfunction

   function automatic logic is_octal(logic [7:0] c);
      return c inside {[CH_ZERO:CH_SEVEN]};
   endfunction

   function automatic logic is_space(logic [7:0] c);
      return (c == CH_SPACE) || (c inside {[CH_TAB:8'h0D]});
   endfunction

   function automatic logic is_punct(logic [7:0] c);
      return c inside {[8'h21:8'h2F], [8'h3A:8'h40], [8'h5B:8'h60], [8'h7B:8'h7E]};
   endfunction

   function automatic result_type mk_byte(logic [7:0] c);
      result_type r;
      r = '0;
      r.out_kind = KIND_VALUE;
      r.value_byte = c;
      return r;
   endfunction

   function automatic result_type mk_end(logic [3:0] tok, logic [3:0] err);
      result_type r;
      r = '0;
      r.out_kind = KIND_END;
      r.token_kind = tok;
      r.error_code = err;
      return r;
   endfunction

   function automatic scan_type scan(lex_state_type st, logic dot, logic [7:0] c);
      scan_type s;
      s.consumed = 1'b1;
      s.has_res = 1'b0;
      s.res = '0;
      s.next_state = st;
      s.next_dot = dot;
      case (st)
         ST_INIT: begin
            if (c == CH_NUL) begin
               s.has_res = 1'b1;
               s.res = mk_end(TOK_EOF, ERR_NONE);
            end else if (is_space(c)) begin
               s.next_state = ST_INIT;
            end else if (c == CH_HASH) begin
               s.next_state = ST_COMMENT;
            end else if (c == CH_UNDERSCORE || is_alpha(c)) begin
               s.has_res = 1'b1;
               s.res = mk_byte(c);
               s.next_state = ST_IDENT;
            end else if (c == CH_QUOTE) begin
               s.next_state = ST_STRING;
            end else if (c == CH_ZERO) begin
               s.has_res = 1'b1;
               s.res = mk_byte(c);
               s.next_state = ST_ZERO;
            end else if (is_digit(c)) begin
               s.has_res = 1'b1;
               s.res = mk_byte(c);
               s.next_state = ST_DECSEQ;
            end else if (is_punct(c)) begin
               s.has_res = 1'b1;
               s.res = mk_byte(c);
               s.next_dot = (c == CH_DOT);
               s.next_state = ST_PUNCT;
            end else begin
               s.has_res = 1'b1;
               s.res = mk_end(TOK_ERROR, ERR_UNKNOWN);
            end
         end
         ST_COMMENT: begin
            if (c == CH_NUL) begin
               s.consumed = 1'b0;
               s.next_state = ST_INIT;
            end else if (c == CH_NL) begin
               s.next_state = ST_INIT;
            end
         end
         ST_IDENT: begin
            if (c == CH_UNDERSCORE || is_alnum(c)) begin
               s.has_res = 1'b1;
               s.res = mk_byte(c);
            end else begin
               s.consumed = 1'b0;
               s.has_res = 1'b1;
               s.res = mk_end(TOK_IDENT, ERR_NONE);
               s.next_state = ST_INIT;
            end
         end
         ST_STRING: begin
            if (c == CH_BACKSLASH) begin
               s.next_state = ST_ESCAPE;
            end else if (c == CH_NUL) begin
               s.has_res = 1'b1;
               s.res = mk_end(TOK_ERROR, ERR_EOF_STR);
               s.next_state = ST_INIT;
            end else if (c == CH_QUOTE) begin
               s.has_res = 1'b1;
               s.res = mk_end(TOK_STR, ERR_NONE);
               s.next_state = ST_INIT;
            end else begin
               s.has_res = 1'b1;
               s.res = mk_byte(c);
            end
         end
         ST_ESCAPE: begin
            s.has_res = 1'b1;
            s.next_state = ST_STRING;
            if (c == CH_NUL) begin
               s.res = mk_end(TOK_ERROR, ERR_EOF_ESC);
               s.next_state = ST_INIT;
            end else if (c == CH_QUOTE) begin
               s.res = mk_byte(CH_QUOTE);
            end else if (c == CH_LOWER_N) begin
               s.res = mk_byte(CH_NL);
            end else if (c == CH_LOWER_T) begin
               s.res = mk_byte(CH_TAB);
            end else if (c == CH_BACKSLASH) begin
               s.res = mk_byte(CH_BACKSLASH);
            end else if (c == CH_ZERO) begin
               s.res = mk_byte(CH_NUL);
            end else begin
               s.consumed = 1'b0;
               s.res = mk_end(TOK_ERROR, ERR_BAD_ESC);
               s.next_state = ST_INIT;
            end
         end
         ST_PUNCT: begin
            s.has_res = 1'b1;
            if (dot && is_digit(c)) begin
               s.res = mk_byte(c);
               s.next_state = ST_FRACSEQ;
            end else begin
               s.consumed = 1'b0;
               s.res = mk_end(TOK_PUNCT, ERR_NONE);
               s.next_state = ST_INIT;
            end
         end
         ST_ZERO: begin
            s.has_res = 1'b1;
            if (c == CH_LOWER_X || c == CH_UPPER_X) begin
               s.res = mk_byte(c);
               s.next_state = ST_HEXREQ;
            end else if (c == CH_DOT) begin
               s.res = mk_byte(c);
               s.next_state = ST_FRACREQ;
            end else if (is_octal(c)) begin
               s.res = mk_byte(c);
               s.next_state = ST_OCTSEQ;
            end else begin
               s.consumed = 1'b0;
               s.res = is_alnum(c) ? mk_end(TOK_ERROR, ERR_DIGIT) : mk_end(TOK_INT, ERR_NONE);
               s.next_state = ST_INIT;
            end
         end
         ST_HEXREQ: begin
            s.has_res = 1'b1;
            if (is_xdigit(c)) begin
               s.res = mk_byte(c);
               s.next_state = ST_HEXSEQ;
            end else begin
               s.consumed = 1'b0;
               s.res = mk_end(TOK_ERROR, ERR_NO_HEX);
               s.next_state = ST_INIT;
            end
         end
         ST_HEXSEQ: begin
            s.has_res = 1'b1;
            if (is_xdigit(c)) begin
               s.res = mk_byte(c);
            end else begin
               s.consumed = 1'b0;
               s.res = is_alnum(c) ? mk_end(TOK_ERROR, ERR_DIGIT) : mk_end(TOK_HEX, ERR_NONE);
               s.next_state = ST_INIT;
            end
         end
         ST_OCTSEQ: begin
            s.has_res = 1'b1;
            if (is_octal(c)) begin
               s.res = mk_byte(c);
            end else begin
               s.consumed = 1'b0;
               s.res = is_alnum(c) ? mk_end(TOK_ERROR, ERR_DIGIT) : mk_end(TOK_OCT, ERR_NONE);
               s.next_state = ST_INIT;
            end
         end
         ST_DECSEQ: begin
            s.has_res = 1'b1;
            if (is_digit(c)) begin
               s.res = mk_byte(c);
            end else if (c == CH_LOWER_E || c == CH_UPPER_E) begin
               s.res = mk_byte(c);
               s.next_state = ST_EXPSIGN;
            end else if (c == CH_DOT) begin
               s.res = mk_byte(c);
               s.next_state = ST_FRACREQ;
            end else begin
               s.consumed = 1'b0;
               s.res = is_alpha(c) ? mk_end(TOK_ERROR, ERR_DIGIT) : mk_end(TOK_INT, ERR_NONE);
               s.next_state = ST_INIT;
            end
         end
         ST_FRACREQ: begin
            s.has_res = 1'b1;
            if (is_digit(c)) begin
               s.res = mk_byte(c);
               s.next_state = ST_FRACSEQ;
            end else begin
               s.consumed = 1'b0;
               s.res = mk_end(TOK_ERROR, ERR_NO_FRAC);
               s.next_state = ST_INIT;
            end
         end
         ST_FRACSEQ: begin
            s.has_res = 1'b1;
            if (is_digit(c)) begin
               s.res = mk_byte(c);
            end else if (c == CH_LOWER_E || c == CH_UPPER_E) begin
               s.res = mk_byte(c);
               s.next_state = ST_EXPSIGN;
            end else begin
               s.consumed = 1'b0;
               s.res = is_alpha(c) ? mk_end(TOK_ERROR, ERR_DIGIT) : mk_end(TOK_REAL, ERR_NONE);
               s.next_state = ST_INIT;
            end
         end
         ST_EXPSIGN: begin
            s.has_res = 1'b1;
            if (c == CH_PLUS || c == CH_MINUS) begin
               s.res = mk_byte(c);
               s.next_state = ST_EXPREQ;
            end else if (is_digit(c)) begin
               s.res = mk_byte(c);
               s.next_state = ST_EXPSEQ;
            end else begin
               s.consumed = 1'b0;
               s.res = mk_end(TOK_ERROR, ERR_NO_EXP);
               s.next_state = ST_INIT;
            end
         end
         ST_EXPREQ: begin
            s.has_res = 1'b1;
            if (is_digit(c)) begin
               s.res = mk_byte(c);
               s.next_state = ST_EXPSEQ;
            end else begin
               s.consumed = 1'b0;
               s.res = mk_end(TOK_ERROR, ERR_NO_EXP);
               s.next_state = ST_INIT;
            end
         end
         default: begin
            s.has_res = 1'b1;
            if (is_digit(c)) begin
               s.res = mk_byte(c);
            end else begin
               s.consumed = 1'b0;
               s.res = is_alpha(c) ? mk_end(TOK_ERROR, ERR_DIGIT) : mk_end(TOK_REAL, ERR_NONE);
               s.next_state = ST_INIT;
            end
         end
      endcase
      return s;
   endfunction

   // A byte that ends a token without joining it goes through a second scan from the
   // initial state, so one byte yields at most two results.
   always_comb begin
      first = scan(state, pending_dot, in_byte);
      second = scan(ST_INIT, first.next_dot, in_byte);
      step_out = '0;
      if (first.consumed) begin
         step_out.next_state = first.next_state;
         step_out.next_dot = first.next_dot;
         step_out.push.count = {1'b0, first.has_res};
         step_out.push.res0 = first.res;
         step_out.push.res0.last = 1'b1;
      end else begin
         step_out.next_state = second.next_state;
         step_out.next_dot = second.next_dot;
         case ({first.has_res, second.has_res})
            2'b11: begin
               step_out.push.count = 2'd2;
               step_out.push.res0 = first.res;
               step_out.push.res1 = second.res;
               step_out.push.res1.last = 1'b1;
            end
            2'b10: begin
               step_out.push.count = 2'd1;
               step_out.push.res0 = first.res;
               step_out.push.res0.last = 1'b1;
            end
            2'b01: begin
               step_out.push.count = 2'd1;
               step_out.push.res0 = second.res;
               step_out.push.res0.last = 1'b1;
            end
            default: begin
               step_out.push.count = 2'd0;
            end
         endcase
      end
   end

endmodule

// ===== hdl/cstl_queue.sv =====
`timescale 1ns / 1ps

module cstl_queue
   import cstl_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  push_type       push,
   output logic           room,
   cstl_rsp_if.source     rsp_if
);

   result_type            entries_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]      rd_ptr_ff;
   logic [PTR_W-1:0]      rd_ptr_in;
   logic [PTR_W-1:0]      wr_ptr_ff;
   logic [PTR_W-1:0]      wr_ptr_in;
   logic [PTR_W-1:0]      wr_next;
   logic [CNT_W-1:0]      count_ff;
   logic [CNT_W-1:0]      count_in;
   logic                  pop;
   result_type            head;

   assign head = entries_ff[rd_ptr_ff];
   assign pop = rsp_if.valid && rsp_if.ready;
   assign wr_next = wr_ptr_ff + PTR_W'(1);
   assign room = count_ff <= CNT_W'(QUEUE_DEPTH - 2);

   assign rsp_if.valid = count_ff != '0;
   assign rsp_if.out_kind = head.out_kind;
   assign rsp_if.value_byte = head.value_byte;
   assign rsp_if.token_kind = head.token_kind;
   assign rsp_if.error_code = head.error_code;
   assign rsp_if.last = head.last;

   always_comb begin
      rd_ptr_in = pop ? rd_ptr_ff + PTR_W'(1) : rd_ptr_ff;
      wr_ptr_in = wr_ptr_ff + PTR_W'(push.count);
      count_in = count_ff + CNT_W'(push.count) - CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ptr_ff <= '0;
         wr_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         rd_ptr_ff <= rd_ptr_in;
         wr_ptr_ff <= wr_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         entries_ff[wr_ptr_ff] <= push.res0;
      end
      if (push.count == 2'd2) begin
         entries_ff[wr_next] <= push.res1;
      end
   end

endmodule

// ===== hdl/c_style_token_lexer_core.sv =====
`timescale 1ns / 1ps

// Streaming C-style lexer. The req channel carries one source byte per beat, a zero
// byte marking end of input. The rsp channel carries one result per beat: either a
// value byte appended to the current token (escapes already translated) or a
// token-end beat with the token kind and error code. Each source byte gives zero,
// one or two result beats, and last marks the final beat caused by that byte.
// A byte lands in an input register at the accepting edge and is scanned in the
// following cycle; its results are written to a four-entry result queue at the
// first edge at which the queue has room, and are then offered on the rsp channel.
// The block accepts one byte per cycle while the queue has room for two results.
// While the receiver is ready, sustained throughput is one byte per cycle as long
// as bytes give at most one result on average; the rsp port delivers one beat per
// cycle, which sets the rate for bytes that close a token and start the next one.
// Reset clears the input register, the queue and the lexer state; the next byte is
// scanned from the initial state. When the receiver stalls, the queue fills, the
// input register holds its byte and req ready drops until space frees up.
module c_style_token_lexer_core
   import cstl_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   cstl_req_if.sink   req_if,
   cstl_rsp_if.source rsp_if
);

   logic          in_valid_ff;
   logic          in_valid_in;
   logic [7:0]    in_byte_ff;
   logic [7:0]    in_byte_in;
   lex_state_type state_ff;
   lex_state_type state_in;
   logic          pending_dot_ff;
   logic          pending_dot_in;
   logic          room;
   logic          advance;
   logic          req_fire;
   step_out_type  step_out;
   push_type      push;

   assign advance = in_valid_ff && room;
   assign req_if.ready = !in_valid_ff || advance;
   assign req_fire = req_if.valid && req_if.ready;

   always_comb begin
      in_valid_in = req_fire ? 1'b1 : (advance ? 1'b0 : in_valid_ff);
      in_byte_in = req_fire ? req_if.in_byte : in_byte_ff;
      state_in = advance ? step_out.next_state : state_ff;
      pending_dot_in = advance ? step_out.next_dot : pending_dot_ff;
      push = step_out.push;
      if (!advance) begin
         push.count = 2'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         state_ff <= ST_INIT;
         pending_dot_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
         state_ff <= state_in;
         pending_dot_ff <= pending_dot_in;
      end
   end

   always_ff @(posedge clock) begin
      in_byte_ff <= in_byte_in;
   end

   cstl_step u_step (
      .in_byte     (in_byte_ff),
      .state       (state_ff),
      .pending_dot (pending_dot_ff),
      .step_out    (step_out)
   );

   cstl_queue u_queue (
      .clock  (clock),
      .reset  (reset),
      .push   (push),
      .room   (room),
      .rsp_if (rsp_if)
   );

`ifndef SYNTHESIS
   a_held_byte: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !advance) |=> (in_valid_ff && $stable(in_byte_ff)))
      else $error("held input byte changed while waiting for queue room");

   a_two_results_last: assert property (@(posedge clock) disable iff (reset)
      (advance && step_out.push.count == 2'd2) |->
      (!step_out.push.res0.last && step_out.push.res1.last))
      else $error("last flag misplaced on a two-result byte");

   a_reset_state: assert property (@(posedge clock)
      reset |=> (state_ff == ST_INIT && !pending_dot_ff && !in_valid_ff))
      else $error("lexer state not cleared by reset");
`endif

endmodule
